FILE: rtl/rpc_frame_deframer_top_assert.svh
// Assertion macros for the frame deframer.
`ifndef RPC_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define RPC_FRAME_DEFRAMER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RPC_FD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpc_fd assertion failed");
`define RPC_FD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpc_fd assertion failed");
`else
`define RPC_FD_ASSERT_NOW(label, ante, cons)
`define RPC_FD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/rpc_fd_pkg.sv
package rpc_fd_pkg;

    localparam int HEADER_BYTES = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TDATA_W      = 208;
    localparam int TUSER_W      = 5;
    localparam int PAD_W        = TDATA_W - 202;

    localparam logic [4:0] OFF_VERSION = 5'd4;
    localparam logic [4:0] OFF_TYPE    = 5'd6;
    localparam logic [4:0] OFF_ID      = 5'd8;
    localparam logic [4:0] OFF_STATUS  = 5'd16;
    localparam logic [4:0] OFF_SVC     = 5'd20;
    localparam logic [4:0] OFF_MTH     = 5'd24;
    localparam logic [4:0] OFF_PAY     = 5'd28;
    localparam logic [4:0] LAST_POS    = 5'(HEADER_BYTES - 1);

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] SEG_SERVICE = 2'd0;
    localparam logic [1:0] SEG_METHOD  = 2'd1;
    localparam logic [1:0] SEG_PAYLOAD = 2'd2;

    localparam logic [1:0] ERR_PREFIX = 2'd0;
    localparam logic [1:0] ERR_TYPE   = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    localparam logic [2:0] CFG_MAGIC     = 3'd0;
    localparam logic [2:0] CFG_VERSION   = 3'd1;
    localparam logic [2:0] CFG_REQUEST   = 3'd2;
    localparam logic [2:0] CFG_RESPONSE  = 3'd3;
    localparam logic [2:0] CFG_MAX_META  = 3'd4;
    localparam logic [2:0] CFG_MAX_BODY  = 3'd5;

    typedef struct packed {
        logic       valid;
        logic [2:0] index;
        logic [31:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [1:0]  segment;
        logic        frame_end;
        logic        frame_kind;
        logic [63:0] call_id;
        logic [31:0] status_word;
        logic [31:0] service_len;
        logic [31:0] method_len;
        logic [31:0] payload_len;
        logic [1:0]  error_code;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: rtl/rpc_fd_front.sv
module rpc_fd_front
    import rpc_fd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_wr_t    cfg_wr,
    input  logic       byte_take,
    input  logic [7:0] byte_data,
    output logic       res_push,
    output res_t       res
);

    typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_ERROR} phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        mismatch_reg, mismatch_next;
    logic [15:0] type_reg, type_next;
    logic [63:0] id_reg, id_next;
    logic [31:0] status_reg, status_next;
    logic [31:0] svc_reg, svc_next;
    logic [31:0] mth_reg, mth_next;
    logic [31:0] pay_reg, pay_next;
    logic [1:0]  seg_reg, seg_next;
    logic [31:0] left_reg, left_next;

    logic [31:0] magic_reg, max_meta_reg, max_body_reg;
    logic [15:0] version_reg, request_reg, response_reg;

    logic [7:0]  magic_byte;
    logic [7:0]  version_byte;
    logic [31:0] pay_full;
    logic [32:0] meta_sum;
    logic        meta_over;
    logic        body_over;
    logic        type_req;
    logic        type_rsp;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0: magic_byte = magic_reg[31:24];
            2'd1: magic_byte = magic_reg[23:16];
            2'd2: magic_byte = magic_reg[15:8];
            2'd3: magic_byte = magic_reg[7:0];
        endcase
    end

    assign version_byte = cnt_reg[0] ? version_reg[7:0] : version_reg[15:8];
    assign pay_full     = {pay_reg[23:0], byte_data};
    assign meta_sum     = {1'b0, svc_reg} + {1'b0, mth_reg};
    assign meta_over    = meta_sum > {1'b0, max_meta_reg};
    assign body_over    = pay_full > max_body_reg;
    assign type_req     = type_reg == request_reg;
    assign type_rsp     = type_reg == response_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        mismatch_next = mismatch_reg;
        type_next     = type_reg;
        id_next       = id_reg;
        status_next   = status_reg;
        svc_next      = svc_reg;
        mth_next      = mth_reg;
        pay_next      = pay_reg;
        seg_next      = seg_reg;
        left_next     = left_reg;
        res_push      = 1'b0;
        res           = '0;
        if (byte_take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    priority if (cnt_reg < OFF_VERSION)
                    begin
                        if (byte_data != magic_byte)
                        begin
                            mismatch_next = 1'b1;
                        end
                    end
                    else if (cnt_reg < OFF_TYPE)
                    begin
                        if (byte_data != version_byte)
                        begin
                            mismatch_next = 1'b1;
                        end
                    end
                    else if (cnt_reg < OFF_ID)
                    begin
                        type_next = {type_reg[7:0], byte_data};
                    end
                    else if (cnt_reg < OFF_STATUS)
                    begin
                        id_next = {id_reg[55:0], byte_data};
                    end
                    else if (cnt_reg < OFF_SVC)
                    begin
                        status_next = {status_reg[23:0], byte_data};
                    end
                    else if (cnt_reg < OFF_MTH)
                    begin
                        svc_next = {svc_reg[23:0], byte_data};
                    end
                    else if (cnt_reg < OFF_PAY)
                    begin
                        mth_next = {mth_reg[23:0], byte_data};
                    end
                    else
                    begin
                        pay_next = pay_full;
                    end

                    if (cnt_reg != LAST_POS)
                    begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                    else
                    begin
                        res_push = 1'b1;
                        priority if (mismatch_reg)
                        begin
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_PREFIX;
                            phase_next     = PH_ERROR;
                        end
                        else if (!type_req && !type_rsp)
                        begin
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_TYPE;
                            phase_next     = PH_ERROR;
                        end
                        else if (meta_over || body_over)
                        begin
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_LENGTH;
                            phase_next     = PH_ERROR;
                        end
                        else
                        begin
                            res.kind        = KIND_HEADER;
                            res.frame_kind  = !type_req;
                            res.call_id     = id_reg;
                            res.status_word = status_reg;
                            res.service_len = svc_reg;
                            res.method_len  = mth_reg;
                            res.payload_len = pay_full;
                            cnt_next        = '0;
                            mismatch_next   = 1'b0;
                            priority if (svc_reg != '0)
                            begin
                                phase_next = PH_BODY;
                                seg_next   = SEG_SERVICE;
                                left_next  = svc_reg;
                            end
                            else if (mth_reg != '0)
                            begin
                                phase_next = PH_BODY;
                                seg_next   = SEG_METHOD;
                                left_next  = mth_reg;
                            end
                            else if (pay_full != '0)
                            begin
                                phase_next = PH_BODY;
                                seg_next   = SEG_PAYLOAD;
                                left_next  = pay_full;
                            end
                            else
                            begin
                                res.frame_end = 1'b1;
                            end
                        end
                    end
                end
                PH_BODY:
                begin
                    res_push      = 1'b1;
                    res.kind      = KIND_BODY;
                    res.data_byte = byte_data;
                    res.segment   = seg_reg;
                    left_next     = left_reg - 32'd1;
                    if (left_reg == 32'd1)
                    begin
                        priority if (seg_reg == SEG_SERVICE && mth_reg != '0)
                        begin
                            seg_next  = SEG_METHOD;
                            left_next = mth_reg;
                        end
                        else if (seg_reg != SEG_PAYLOAD && pay_reg != '0)
                        begin
                            seg_next  = SEG_PAYLOAD;
                            left_next = pay_reg;
                        end
                        else
                        begin
                            phase_next    = PH_HEADER;
                            cnt_next      = '0;
                            mismatch_next = 1'b0;
                            res.frame_end = 1'b1;
                        end
                    end
                end
                PH_ERROR:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            cnt_reg      <= '0;
            mismatch_reg <= 1'b0;
            type_reg     <= '0;
            id_reg       <= '0;
            status_reg   <= '0;
            svc_reg      <= '0;
            mth_reg      <= '0;
            pay_reg      <= '0;
            seg_reg      <= SEG_SERVICE;
            left_reg     <= '0;
            magic_reg    <= 32'd0;
            version_reg  <= 16'd0;
            request_reg  <= 16'd0;
            response_reg <= 16'd1;
            max_meta_reg <= 32'd4096;
            max_body_reg <= 32'd16777216;
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            mismatch_reg <= mismatch_next;
            type_reg     <= type_next;
            id_reg       <= id_next;
            status_reg   <= status_next;
            svc_reg      <= svc_next;
            mth_reg      <= mth_next;
            pay_reg      <= pay_next;
            seg_reg      <= seg_next;
            left_reg     <= left_next;
            if (cfg_wr.valid)
            begin
                unique case (cfg_wr.index)
                    CFG_MAGIC:    magic_reg    <= cfg_wr.data;
                    CFG_VERSION:  version_reg  <= cfg_wr.data[15:0];
                    CFG_REQUEST:  request_reg  <= cfg_wr.data[15:0];
                    CFG_RESPONSE: response_reg <= cfg_wr.data[15:0];
                    CFG_MAX_META: max_meta_reg <= cfg_wr.data;
                    CFG_MAX_BODY: max_body_reg <= cfg_wr.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/rpc_fd_queue.sv
module rpc_fd_queue
    import rpc_fd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  res_t    push_data,
    input  logic    pop,
    output res_t    pop_data,
    output q_stat_t stat
);

    res_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/rpc_fd_back.sv
module rpc_fd_back
    import rpc_fd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  res_t               q_data,
    input  logic               q_avail,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TDATA_W-1:0] m_data,
    output logic [TUSER_W-1:0] m_user,
    output logic               m_last
);

    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic [TUSER_W-1:0] user_reg, user_next;
    logic               last_reg, last_next;

    assign q_pop = q_avail && (!valid_reg || m_ready);

    always_comb
    begin
        data_next = {{PAD_W{1'b0}}, q_data.error_code, q_data.payload_len, q_data.method_len,
                     q_data.service_len, q_data.status_word, q_data.call_id, q_data.data_byte};
        user_next = {q_data.frame_kind, q_data.segment, q_data.kind};
        last_next = q_data.frame_end;
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
    assign m_user  = user_reg;
    assign m_last  = last_reg;

endmodule

FILE: rtl/rpc_frame_deframer_top.sv
// channel   direction  contents
// s_axis    in         tdata: rx_byte
// m_axis    out        tdata: data_byte, call_id, status_word, lengths, error_code
//                      tuser: kind, segment, frame_kind; tlast: frame_end
// cfg       in         cfg_index selects register, cfg_data its value
//
// One byte per cycle while s_axis_tready is high; each header byte is one shift or
// compare, the last header byte also runs the type and length checks in the same
// cycle. A result word passes through the result queue, then the output register.
// Reset clears the control state and loads register defaults; an error holds
// until reset. A stalled output fills the two-entry queue, then s_axis_tready drops.
`include "rpc_frame_deframer_top_assert.svh"

module rpc_frame_deframer_top
    import rpc_fd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // data_byte, call_id, status_word,
                                               // service_len, method_len, payload_len,
                                               // error_code, zero pad
    output logic [TUSER_W-1:0] m_axis_tuser,   // kind, segment, frame_kind
    output logic               m_axis_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cfg_wr_t cfg_wr;
    q_stat_t q_stat;
    res_t    front_res;
    res_t    q_data;
    logic    front_push;
    logic    q_pop;
    logic    byte_take;

    assign cfg_ready     = 1'b1;
    assign cfg_wr.valid  = cfg_valid;
    assign cfg_wr.index  = cfg_index;
    assign cfg_wr.data   = cfg_data;
    assign s_axis_tready = !q_stat.full;
    assign byte_take     = s_axis_tvalid && s_axis_tready;

    rpc_fd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .byte_take (byte_take),
        .byte_data (s_axis_tdata),
        .res_push  (front_push),
        .res       (front_res)
    );

    rpc_fd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_res),
        .pop       (q_pop),
        .pop_data  (q_data),
        .stat      (q_stat)
    );

    rpc_fd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_avail (!q_stat.empty),
        .q_pop   (q_pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_user  (m_axis_tuser),
        .m_last  (m_axis_tlast)
    );

    `RPC_FD_ASSERT_NEXT(a_error_is_final, m_axis_tvalid && m_axis_tready && m_axis_tuser[1:0] == KIND_ERROR, !m_axis_tvalid && q_stat.empty)
    `RPC_FD_ASSERT_NOW(a_error_not_last, m_axis_tvalid && m_axis_tuser[1:0] == KIND_ERROR, !m_axis_tlast)
    `RPC_FD_ASSERT_NOW(a_body_segment, m_axis_tvalid && m_axis_tuser[1:0] == KIND_BODY, m_axis_tuser[3:2] != 2'd3)
    `RPC_FD_ASSERT_NOW(a_no_push_full, front_push, !q_stat.full)

endmodule
